// ===== rtl/tgi_pkg.sv =====
// Shared types and constants for the trilinear grid interpolator.
// No dependencies; used by tgi_out_fifo and trilinear_grid_interpolator.
`default_nettype none
package tgi_pkg;

  // axis point counts (defaults)
  localparam int N1_POINTS_DEF = 16;
  localparam int N2_POINTS_DEF = 16;
  localparam int NY_POINTS_DEF = 32;

  // result queue depth; covers the pipeline latency at full rate
  localparam int OUT_FIFO_DEPTH = 8;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 31;

  localparam logic [CFG_IDX_W-1:0] REG_FF1_MAX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF2_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEPY = 3'd5;

  localparam logic [CFG_W-1:0] FF1_MAX_RST   = 31'd65536;
  localparam logic [CFG_W-1:0] FF2_MAX_RST   = 31'd65536;
  localparam logic [CFG_W-1:0] Y_MAX_RST     = 31'd655360;
  localparam logic [CFG_W-1:0] INV_STEP1_RST = 31'd983040;
  localparam logic [CFG_W-1:0] INV_STEP2_RST = 31'd983040;
  localparam logic [CFG_W-1:0] INV_STEPY_RST = 31'd101580;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // per-stage control
  typedef struct packed {
    logic    valid;
    logic    query;
    status_t status;
  } ctl_t;

  typedef struct packed {
    logic [31:0] result;
    status_t     status;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/tgi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module tgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/tgi_out_fifo.sv =====
// Result queue between the blend pipeline and the output channel.
// Depends on tgi_pkg (out_item_t).
`default_nettype none
module tgi_out_fifo #(
  parameter int DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire tgi_pkg::out_item_t            push_data,
  input  wire logic                          pop,
  output tgi_pkg::out_item_t                 head,
  output logic [$clog2(DEPTH+1)-1:0]         level
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  tgi_pkg::out_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (int'(p) == DEPTH-1) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      level <= level + LW'(push) - LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign head = mem[rd_ptr];
endmodule
`default_nettype wire

// ===== rtl/trilinear_grid_interpolator.sv =====
// Top level of the trilinear grid interpolator: binning, banked corner
// fetch, blend pipeline, result queue. Depends on tgi_pkg, tgi_ram, tgi_out_fifo.
//
// Usage:
//  - in channel (in_valid/in_ready): mode 0 loads load_value at (load_i,
//    load_j, load_k); mode 1 queries the blend at (ff1, ff2, rapidity).
//    Each item gives exactly one result item on the out channel.
//  - out channel (out_valid/out_ready): result and status, in input order.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//    always ready; write only while the block is idle.
//  - Path: an accepted item passes stage registers A to F and the result
//    queue before out_valid rises; with out_ready high the result item is taken.
//  - Throughput: one item per cycle while in_ready is high. The table is split in eight banks by
//    the parity of (i, j, k), so the eight corners come out in one read.
//  - A credit counter bounds items in flight plus queued results by the
//    8-entry result queue; when the receiver stalls, in_ready drops once
//    that queue would be full and returns as results drain.
//  - Reset clears control and registers; table contents are undefined until
//    loaded (no clearing pass).
`default_nettype none
module trilinear_grid_interpolator #(
  parameter int N1_POINTS = tgi_pkg::N1_POINTS_DEF,
  parameter int N2_POINTS = tgi_pkg::N2_POINTS_DEF,
  parameter int NY_POINTS = tgi_pkg::NY_POINTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           mode,
  input  wire logic signed [31:0]             ff1,
  input  wire logic signed [31:0]             ff2,
  input  wire logic signed [31:0]             rapidity,
  input  wire logic [3:0]                     load_i,
  input  wire logic [3:0]                     load_j,
  input  wire logic [4:0]                     load_k,
  input  wire logic signed [31:0]             load_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [31:0]                  result,
  output logic [1:0]                          status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tgi_pkg::CFG_W-1:0]      cfg_data
);
  // bank geometry: each bank holds one parity class of (i, j, k)
  localparam int H1 = (N1_POINTS + 1) / 2;
  localparam int H2 = (N2_POINTS + 1) / 2;
  localparam int HY = (NY_POINTS + 1) / 2;
  localparam int BANK_DEPTH = H1 * H2 * HY;
  localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int I1W = $clog2(N1_POINTS);
  localparam int I2W = $clog2(N2_POINTS);
  localparam int KW  = $clog2(NY_POINTS);
  localparam int FD  = tgi_pkg::OUT_FIFO_DEPTH;
  localparam int CW  = $clog2(FD + 1);

  // ---------------- configuration registers ----------------
  logic [30:0] ff1_max, ff2_max, y_max, inv_step1, inv_step2, inv_stepy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff1_max   <= tgi_pkg::FF1_MAX_RST;
      ff2_max   <= tgi_pkg::FF2_MAX_RST;
      y_max     <= tgi_pkg::Y_MAX_RST;
      inv_step1 <= tgi_pkg::INV_STEP1_RST;
      inv_step2 <= tgi_pkg::INV_STEP2_RST;
      inv_stepy <= tgi_pkg::INV_STEPY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tgi_pkg::REG_FF1_MAX:   ff1_max   <= cfg_data;
        tgi_pkg::REG_FF2_MAX:   ff2_max   <= cfg_data;
        tgi_pkg::REG_Y_MAX:     y_max     <= cfg_data;
        tgi_pkg::REG_INV_STEP1: inv_step1 <= cfg_data;
        tgi_pkg::REG_INV_STEP2: inv_step2 <= cfg_data;
        tgi_pkg::REG_INV_STEPY: inv_stepy <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------- credits ----------------
  logic [CW-1:0] credits;
  logic [CW-1:0] fifo_level;
  logic in_acc, out_acc;

  assign in_ready = (credits < CW'(FD));
  assign in_acc   = in_valid & in_ready;
  assign out_acc  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) credits <= '0;
    else     credits <= credits + CW'(in_acc) - CW'(out_acc);
  end

  // ---------------- accept cycle: offsets and bin products ----------------
  logic signed [33:0] diff1, diff2, ysum, y_ext;
  logic               ylow_n, yhigh_n;

  always_comb begin
    y_ext   = {{2{rapidity[31]}}, rapidity};
    diff1   = $signed({3'b0, ff1_max}) - $signed({{2{ff1[31]}}, ff1});
    diff2   = $signed({3'b0, ff2_max}) - $signed({{2{ff2[31]}}, ff2});
    ysum    = y_ext + $signed({3'b0, y_max});
    ylow_n  = (ysum <= 34'sd0);              // at or below -y_max
    yhigh_n = (y_ext >= $signed({3'b0, y_max}));
  end

  // stage A
  tgi_pkg::ctl_t ctl_a;
  logic          zero_a, neg1_a, neg2_a, ylow_a, yhigh_a;
  logic [62:0]   f1_a, f2_a, fy_a;
  logic [3:0]    li_a, lj_a;
  logic [4:0]    lk_a;
  logic [31:0]   lval_a;

  always_ff @(posedge clk) begin
    if (rst) ctl_a <= '0;
    else begin
      ctl_a.valid  <= in_acc;
      ctl_a.query  <= mode;
      ctl_a.status <= tgi_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    zero_a  <= (ff1 == 32'sd0) || (ff2 == 32'sd0);
    neg1_a  <= diff1[33];
    neg2_a  <= diff2[33];
    ylow_a  <= ylow_n;
    yhigh_a <= yhigh_n;
    f1_a    <= {31'b0, diff1[31:0]} * {32'b0, inv_step1};
    f2_a    <= {31'b0, diff2[31:0]} * {32'b0, inv_step2};
    fy_a    <= {31'b0, ysum[31:0]} * {32'b0, inv_stepy};
    li_a    <= load_i;
    lj_a    <= load_j;
    lk_a    <= load_k;
    lval_a  <= load_value;
  end

  // ---------------- stage A: bins, status, bank addresses ----------------
  logic           bilin;
  logic [I1W-1:0] b1;
  logic [I2W-1:0] b2;
  logic [KW-1:0]  by;
  logic [15:0]    ty;
  tgi_pkg::status_t st_a;
  logic [I1W-1:0] ci [8];
  logic [I2W-1:0] cj [8];
  logic [KW-1:0]  ck [8];
  logic [2:0]     sel_a [8];   // {a, b, c} corner offsets per bank
  logic           mask_a [8];  // bank not used by a bilinear blend
  logic [BAW-1:0] raddr [8];
  logic [BAW-1:0] laddr;
  logic [2:0]     lbank;
  logic           lok;

  always_comb begin
    bilin = ylow_a | yhigh_a;
    b1 = f1_a[32 +: I1W];
    b2 = f2_a[32 +: I2W];
    if (ylow_a)       by = '0;
    else if (yhigh_a) by = KW'(NY_POINTS - 1);
    else              by = fy_a[32 +: KW];
    ty = bilin ? 16'd0 : fy_a[31:16];

    priority if (zero_a)
      st_a = tgi_pkg::ST_ZERO;
    else if (neg1_a || neg2_a || f1_a[62:32] >= 31'(N1_POINTS - 1) ||
             f2_a[62:32] >= 31'(N2_POINTS - 1))
      st_a = tgi_pkg::ST_RANGE;
    else if (!bilin && fy_a[62:32] >= 31'(NY_POINTS - 1))
      st_a = tgi_pkg::ST_RANGE;
    else
      st_a = tgi_pkg::ST_OK;

    for (int p = 0; p < 8; p++) begin
      sel_a[p][2] = 1'(p >> 2) ^ b1[0];
      sel_a[p][1] = 1'(p >> 1) ^ b2[0];
      sel_a[p][0] = 1'(p) ^ by[0];
      ci[p] = b1 + I1W'(sel_a[p][2]);
      cj[p] = b2 + I2W'(sel_a[p][1]);
      ck[p] = bilin ? by : by + KW'(sel_a[p][0]);
      mask_a[p] = bilin & sel_a[p][0];
      raddr[p] = BAW'((int'(ci[p] >> 1) * H2 + int'(cj[p] >> 1)) * HY +
                      int'(ck[p] >> 1));
    end

    lok   = (int'(li_a) < N1_POINTS) && (int'(lj_a) < N2_POINTS) &&
            (int'(lk_a) < NY_POINTS);
    lbank = {li_a[0], lj_a[0], lk_a[0]};
    laddr = BAW'((int'(li_a >> 1) * H2 + int'(lj_a >> 1)) * HY + int'(lk_a >> 1));
  end

  // banks: a load writes in stage A, a later query reads in its own stage A
  // after that write, so accesses never overlap
  logic [31:0] rdata [8];

  for (genvar g = 0; g < 8; g++) begin : g_bank
    tgi_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_bank (
      .clk   (clk),
      .we    (ctl_a.valid & ~ctl_a.query & lok & (lbank == 3'(g))),
      .waddr (laddr),
      .wdata (lval_a),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  // ---------------- stage B: axis weights, corner data ----------------
  tgi_pkg::ctl_t ctl_b, ctl_c, ctl_d, ctl_e, ctl_f;
  logic [16:0] w1_b [2];
  logic [16:0] w2_b [2];
  logic [16:0] wy_b [2];
  logic [2:0]  sel_b [8];
  logic        mask_b [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
      ctl_c <= '0;
      ctl_d <= '0;
      ctl_e <= '0;
      ctl_f <= '0;
    end else begin
      ctl_b.valid  <= ctl_a.valid;
      ctl_b.query  <= ctl_a.query;
      ctl_b.status <= ctl_a.query ? st_a : tgi_pkg::ST_OK;
      ctl_c <= ctl_b;
      ctl_d <= ctl_c;
      ctl_e <= ctl_d;
      ctl_f <= ctl_e;
    end
  end

  always_ff @(posedge clk) begin
    w1_b[0] <= 17'd65536 - {1'b0, f1_a[31:16]};
    w1_b[1] <= {1'b0, f1_a[31:16]};
    w2_b[0] <= 17'd65536 - {1'b0, f2_a[31:16]};
    w2_b[1] <= {1'b0, f2_a[31:16]};
    wy_b[0] <= 17'd65536 - {1'b0, ty};
    wy_b[1] <= {1'b0, ty};
    sel_b   <= sel_a;
    mask_b  <= mask_a;
  end

  // ---------------- stage C: form-factor weight products ----------------
  logic [16:0]        w12_c [8];
  logic [16:0]        wy_c  [8];
  logic signed [31:0] data_c [8];
  logic [33:0]        m12 [8];

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      m12[p] = {17'b0, w1_b[sel_b[p][2]]} * {17'b0, w2_b[sel_b[p][1]]};
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 8; p++) begin
      w12_c[p]  <= m12[p][32:16];
      wy_c[p]   <= wy_b[sel_b[p][0]];
      data_c[p] <= mask_b[p] ? 32'sd0 : $signed(rdata[p]);
    end
  end

  // ---------------- stage D: rapidity weight ----------------
  logic [16:0]        w_d [8];
  logic signed [31:0] data_d [8];
  logic [33:0]        m3 [8];

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      m3[p] = {17'b0, w12_c[p]} * {17'b0, wy_c[p]};
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 8; p++) begin
      w_d[p]    <= m3[p][32:16];
      data_d[p] <= data_c[p];
    end
  end

  // ---------------- stage E: weighted corners ----------------
  logic signed [49:0] prod_e [8];

  always_ff @(posedge clk) begin
    for (int p = 0; p < 8; p++) begin
      prod_e[p] <= $signed({33'b0, w_d[p]}) * $signed({{18{data_d[p][31]}}, data_d[p]});
    end
  end

  // ---------------- stage F: pair sums ----------------
  logic signed [50:0] pair_f [4];

  always_ff @(posedge clk) begin
    for (int q = 0; q < 4; q++) begin
      pair_f[q] <= $signed({prod_e[2*q][49], prod_e[2*q]}) +
                   $signed({prod_e[2*q+1][49], prod_e[2*q+1]});
    end
  end

  // ---------------- final sum, floor shift, saturate ----------------
  logic signed [52:0] total;
  logic signed [36:0] shifted;
  logic signed [31:0] sat;
  tgi_pkg::out_item_t push_item, head;

  always_comb begin
    total = $signed({{2{pair_f[0][50]}}, pair_f[0]}) +
            $signed({{2{pair_f[1][50]}}, pair_f[1]}) +
            $signed({{2{pair_f[2][50]}}, pair_f[2]}) +
            $signed({{2{pair_f[3][50]}}, pair_f[3]});
    shifted = total[52:16];  // arithmetic shift = floor
    if (shifted > 37'sh0_7FFF_FFFF)
      sat = 32'sh7FFF_FFFF;
    else if (shifted < -37'sh0_8000_0000)
      sat = -32'sh8000_0000;
    else
      sat = shifted[31:0];
    push_item.status = ctl_f.status;
    push_item.result = (ctl_f.query && ctl_f.status == tgi_pkg::ST_OK) ?
                       sat : 32'd0;
  end

  tgi_out_fifo #(.DEPTH(FD)) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl_f.valid),
    .push_data (push_item),
    .pop       (out_acc),
    .head      (head),
    .level     (fifo_level)
  );

  assign out_valid = (fifo_level != '0);
  assign result    = head.result;
  assign status    = head.status;

  // ---------------- assertions ----------------
  a_credit_balance: assert property (@(posedge clk) disable iff (rst)
    credits == CW'(ctl_a.valid) + CW'(ctl_b.valid) + CW'(ctl_c.valid) +
               CW'(ctl_d.valid) + CW'(ctl_e.valid) + CW'(ctl_f.valid) + fifo_level)
    else $error("credit count out of step with items in flight");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl_f.valid |-> fifo_level < CW'(FD) || out_acc)
    else $error("result queue overflow");

  a_load_status: assert property (@(posedge clk) disable iff (rst)
    ctl_f.valid && !ctl_f.query |-> ctl_f.status == tgi_pkg::ST_OK &&
                                     push_item.result == 32'd0)
    else $error("load item produced a nonzero result");

endmodule
`default_nettype wire
